>>> rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes, tables and helpers of the pen coil scan sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int TICKS_PER_US_DEF = 72;
  localparam int NUM_FREQS        = 12;
  localparam int LOW_OVERHEAD     = 3;
  localparam int HIGH_OVERHEAD    = 7;

  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 20;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEN    = 3'd5;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT     = 3'd1;
  localparam logic [2:0] PH_BURST    = 3'd2;
  localparam logic [2:0] PH_SETTLE_A = 3'd3;
  localparam logic [2:0] PH_SETTLE_B = 3'd4;
  localparam logic [2:0] PH_SAMPLE   = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_start;
    logic fin;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [3:0] freq_sel(input logic [3:0] f);
    logic [3:0] r;
    r = f;
    if (32'(r) >= NUM_FREQS) r = 4'(NUM_FREQS - 1);
    if (r > 4'd11) r = 4'd11;
    return r;
  endfunction

  function automatic logic [6:0] low_half(input logic [3:0] i);
    logic [6:0] v;
    unique case (i)
      4'd0:    v = 7'd75;
      4'd1:    v = 7'd74;
      4'd2:    v = 7'd72;
      4'd3:    v = 7'd71;
      4'd4:    v = 7'd69;
      4'd5:    v = 7'd68;
      4'd6:    v = 7'd67;
      4'd7:    v = 7'd66;
      4'd8:    v = 7'd65;
      4'd9:    v = 7'd64;
      4'd10:   v = 7'd63;
      default: v = 7'd62;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] high_half(input logic [3:0] i);
    logic [6:0] v;
    unique case (i)
      4'd0:    v = 7'd71;
      4'd1:    v = 7'd68;
      4'd2:    v = 7'd68;
      4'd3:    v = 7'd65;
      4'd4:    v = 7'd65;
      4'd5:    v = 7'd62;
      4'd6:    v = 7'd63;
      4'd7:    v = 7'd61;
      4'd8:    v = 7'd60;
      4'd9:    v = 7'd59;
      4'd10:   v = 7'd58;
      default: v = 7'd56;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] mux_decode(input logic [1:0] sel);
    return ~(4'b0001 << sel);
  endfunction

  function automatic logic [SAMPLE_W-1:0] median3(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b,
                                                  input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

>>> rtl/core/pen_coil_scan_sequencer.sv
// ----------------------------------------------------------------------------
// pen_coil_scan_sequencer
// Pen coil measurement sequencer with grid-aligned start and sample reduction.
// ----------------------------------------------------------------------------
// Each input transaction (tick, start or ADC sample) yields exactly one output
// transaction carrying the pin levels and status after that item. One item
// at a time is in flight: a tick, a plain start or a median sample goes from
// acceptance through execute to output load. A start that skips grid periods and
// the last sample of a mean also pass through the bit-serial restoring divider
// between execute and output load. Configuration writes are taken on any cycle
// with cfg_we_i high.
module pen_coil_scan_sequencer #(
  parameter int TICKS_PER_US = pcs_pkg::TICKS_PER_US_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tx_mux[1:0] tx_channel[4:2] rx_mux[6:5] rx_channel[9:7] freq[13:10] sample[25:14]
  input  logic [pcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [pcs_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // coil_drive[0] drive_enable[1] listen[2] mux_channel[5:3] mux_enable_n[9:6]
  // gain_attenuate[10] adc_start[11] busy_res[12] done_res[13] value[25:14]
  output logic [pcs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcs_pkg::CFG_DAT_W-1:0]  cfg_wdata_i
);

  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pcs_datapath #(.TICKS_PER_US(TICKS_PER_US)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/core/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [DEN_W:0]   sh;
  logic             ge;

  always_comb begin
    sh    = {rem_q, num_q[NUM_W-1]};
    ge    = sh >= {1'b0, den_q};
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      run_d  = 1'b1;
      done_d = 1'b0;
    end else if (run_q) begin
      rem_d = ge ? DEN_W'(sh - {1'b0, den_q}) : DEN_W'(sh);
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/pcs_datapath.sv
// ----------------------------------------------------------------------------
// pcs_datapath
// Measurement state, grid arithmetic, sample reduction and output register.
// ----------------------------------------------------------------------------
module pcs_datapath #(
  parameter int TICKS_PER_US = pcs_pkg::TICKS_PER_US_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcs_pkg::cmd_t                     cmd_i,
  output pcs_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pcs_pkg::CFG_DAT_W-1:0]     cfg_wdata_i,
  input  logic [pcs_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [pcs_pkg::OP_W-1:0]          in_op_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pcs_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int PERIOD_W = $clog2(250 * TICKS_PER_US + 1);
  localparam int TIMER_W  = $clog2(1023 * TICKS_PER_US + 1);
  localparam int LATE_W   = $clog2(250000 * TICKS_PER_US + 1);
  localparam int NUM_W    = (LATE_W > pcs_pkg::SUM_W) ? LATE_W : pcs_pkg::SUM_W;
  localparam int DEN_W    = (PERIOD_W > 8) ? PERIOD_W : 8;
  localparam int SW       = pcs_pkg::SAMPLE_W;

  // configuration
  logic [9:0] settle_a_q, settle_b_q;
  logic [7:0] burst_q, period_us_q, mean_cnt_q;
  logic       atten_q;

  // latched item
  logic [pcs_pkg::OP_W-1:0] op_q;
  logic [1:0]  tx_mux_q, rx_mux_q;
  logic [2:0]  tx_ch_q, rx_ch_q;
  logic [3:0]  freq_q;
  logic [SW-1:0] smp_q;

  // measurement state
  logic [31:0]        time_q, time_d, grid_q, grid_d, launch_q, launch_d;
  logic               restart_q, restart_d;
  logic [2:0]         phase_q, phase_d;
  logic [TIMER_W-1:0] timer_q, timer_d, tdec;
  logic [8:0]         bursts_q, bursts_d;
  logic [13:0]        setup_q, setup_d;
  logic [pcs_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [7:0]         taken_q, taken_d, needed_q, needed_d;
  logic               mean_q, mean_d;
  logic [SW-1:0]      med_q [3];
  logic [SW-1:0]      med_d [3];
  logic               coil_q, coil_d, drv_q, drv_d, lsn_q, lsn_d;
  logic [2:0]         mch_q, mch_d;
  logic [3:0]         men_q, men_d;
  logic [NUM_W-1:0]   late_q, late_d;
  logic               kind_mean_q, kind_mean_d;
  logic               res_adc_q, res_adc_d, res_done_q, res_done_d;
  logic [SW-1:0]      res_val_q, res_val_d;
  logic [pcs_pkg::OUT_DATA_W-1:0] out_q;
  logic               out_vld_q;

  // working signals
  logic [PERIOD_W-1:0] period;
  logic [31:0]         gn, diff;
  logic signed [33:0]  late_s, lim_hi, lim_lo;
  logic                grid_go, launch_go, meas_end, need_div;
  logic [3:0]          fidx;
  logic [DEN_W-1:0]    den, adj;
  logic                div_done;
  logic [NUM_W-1:0]    quot;
  logic [DEN_W-1:0]    rem;

  assign period = PERIOD_W'(period_us_q * TICKS_PER_US);
  assign den    = kind_mean_q ? DEN_W'(needed_q) : DEN_W'(period);
  assign fidx   = pcs_pkg::freq_sel(setup_q[13:10]);
  assign tdec   = (timer_q != '0) ? timer_q - 1'b1 : timer_q;

  pcs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (late_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  always_comb begin
    time_d = time_q;  grid_d = grid_q;  launch_d = launch_q;
    restart_d = restart_q;  phase_d = phase_q;  timer_d = timer_q;
    bursts_d = bursts_q;  setup_d = setup_q;  sum_d = sum_q;
    taken_d = taken_q;  needed_d = needed_q;  mean_d = mean_q;
    med_d = med_q;
    coil_d = coil_q;  drv_d = drv_q;  lsn_d = lsn_q;
    mch_d = mch_q;  men_d = men_q;
    late_d = late_q;  kind_mean_d = kind_mean_q;
    res_adc_d = res_adc_q;  res_done_d = res_done_q;  res_val_d = res_val_q;
    grid_go = 1'b0;  launch_go = 1'b0;  meas_end = 1'b0;  need_div = 1'b0;
    gn = grid_q;
    diff = '0;
    adj = '0;
    late_s = '0;
    lim_hi = 34'(period * 1000);
    lim_lo = 34'(period * 4);

    if (cmd_i.exec) begin
      res_adc_d  = 1'b0;
      res_done_d = 1'b0;
      res_val_d  = '0;
      unique case (op_q)
        pcs_pkg::OP_TICK: begin
          time_d = time_q + 1'b1;
          unique case (phase_q)
            pcs_pkg::PH_WAIT: begin
              if (!diff[31] && !(time_d - launch_q >= 32'h8000_0000)) launch_go = 1'b1;
            end
            pcs_pkg::PH_BURST: begin
              timer_d = tdec;
              if (tdec == '0) begin
                if (!coil_q) begin
                  coil_d  = 1'b1;
                  timer_d = TIMER_W'(pcs_pkg::high_half(fidx)) +
                            TIMER_W'(pcs_pkg::HIGH_OVERHEAD);
                end else if (bursts_q > 9'd1) begin
                  bursts_d = bursts_q - 1'b1;
                  coil_d   = 1'b0;
                  timer_d  = TIMER_W'(pcs_pkg::low_half(fidx)) +
                             TIMER_W'(pcs_pkg::LOW_OVERHEAD);
                end else begin
                  // burst over: switch to the receive coil
                  bursts_d = '0;
                  coil_d   = 1'b1;
                  drv_d    = 1'b0;
                  men_d    = pcs_pkg::mux_decode(setup_q[9:8]);
                  mch_d    = setup_q[7:5];
                  timer_d  = TIMER_W'(settle_a_q * TICKS_PER_US);
                  phase_d  = pcs_pkg::PH_SETTLE_A;
                end
              end
            end
            pcs_pkg::PH_SETTLE_A: begin
              timer_d = tdec;
              if (tdec == '0) begin
                lsn_d   = 1'b1;
                timer_d = TIMER_W'(settle_b_q * TICKS_PER_US);
                phase_d = pcs_pkg::PH_SETTLE_B;
              end
            end
            pcs_pkg::PH_SETTLE_B: begin
              timer_d = tdec;
              if (tdec == '0) begin
                mean_d    = mean_cnt_q != 8'd0;
                needed_d  = (mean_cnt_q != 8'd0) ? mean_cnt_q : 8'd3;
                taken_d   = '0;
                sum_d     = '0;
                res_adc_d = 1'b1;
                phase_d   = pcs_pkg::PH_SAMPLE;
              end
            end
            default: ;
          endcase
        end
        pcs_pkg::OP_START: begin
          if (phase_q == pcs_pkg::PH_IDLE) begin
            setup_d = {freq_q, rx_mux_q, rx_ch_q, tx_mux_q, tx_ch_q};
            if (period_us_q == 8'd0) begin
              launch_go = 1'b1;
            end else begin
              gn = restart_q ? time_q : grid_q;
              restart_d = 1'b0;
              diff   = time_q - gn;
              late_s = {{2{diff[31]}}, diff};
              if (late_s > lim_hi || late_s < -lim_lo) begin
                gn = time_q;
                grid_go = 1'b1;
              end else if (late_s > 34'sd0) begin
                // skip whole periods: finish after the divider
                need_div    = 1'b1;
                kind_mean_d = 1'b0;
                grid_d      = gn;
                late_d      = NUM_W'(diff);
              end else begin
                grid_go = 1'b1;
              end
            end
          end
        end
        pcs_pkg::OP_SAMPLE: begin
          if (phase_q == pcs_pkg::PH_SAMPLE) begin
            if (mean_q) sum_d = sum_q + pcs_pkg::SUM_W'(smp_q);
            else if (taken_q < 8'd3) med_d[taken_q[1:0]] = smp_q;
            taken_d = taken_q + 1'b1;
            if (taken_d >= needed_q) begin
              if (mean_q) begin
                need_div    = 1'b1;
                kind_mean_d = 1'b1;
                late_d      = NUM_W'(sum_d);
              end else begin
                res_val_d = pcs_pkg::median3(med_d[0], med_d[1], med_d[2]);
                meas_end  = 1'b1;
              end
            end else begin
              res_adc_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.fin) begin
      if (kind_mean_q) begin
        res_val_d = quot[SW-1:0];
        meas_end  = 1'b1;
      end else begin
        adj = (rem == '0) ? '0 : DEN_W'(period) - rem;
        gn  = grid_q + 32'(late_q) + 32'(adj);
        grid_go = 1'b1;
      end
    end

    if (grid_go) begin
      launch_d = gn;
      grid_d   = gn + 32'(period);
      if (!(time_q - gn >= 32'h8000_0000)) launch_go = 1'b1;
      else phase_d = pcs_pkg::PH_WAIT;
    end

    if (launch_go) begin
      mch_d    = setup_d[2:0];
      men_d    = pcs_pkg::mux_decode(setup_d[4:3]);
      coil_d   = 1'b0;
      drv_d    = 1'b1;
      bursts_d = 9'(burst_q) + 9'd1;
      timer_d  = TIMER_W'(pcs_pkg::low_half(pcs_pkg::freq_sel(setup_d[13:10]))) +
                 TIMER_W'(pcs_pkg::LOW_OVERHEAD);
      phase_d  = pcs_pkg::PH_BURST;
    end

    if (meas_end) begin
      res_done_d = 1'b1;
      lsn_d      = 1'b0;
      men_d      = 4'hF;
      phase_d    = pcs_pkg::PH_IDLE;
    end

    // a new grid period restarts the grid on the next start
    if (cfg_we_i && cfg_idx_i == pcs_pkg::REG_PERIOD) restart_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_a_q  <= 10'd18;
      settle_b_q  <= 10'd18;
      burst_q     <= 8'd18;
      period_us_q <= 8'd130;
      mean_cnt_q  <= 8'd0;
      atten_q     <= 1'b0;
      time_q      <= '0;
      grid_q      <= '0;
      launch_q    <= '0;
      restart_q   <= 1'b1;
      phase_q     <= pcs_pkg::PH_IDLE;
      timer_q     <= '0;
      bursts_q    <= '0;
      setup_q     <= '0;
      sum_q       <= '0;
      taken_q     <= '0;
      needed_q    <= '0;
      mean_q      <= 1'b0;
      med_q[0]    <= '0;
      med_q[1]    <= '0;
      med_q[2]    <= '0;
      coil_q      <= 1'b0;
      drv_q       <= 1'b0;
      lsn_q       <= 1'b0;
      mch_q       <= '0;
      men_q       <= 4'hF;
      kind_mean_q <= 1'b0;
      res_adc_q   <= 1'b0;
      res_done_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      time_q      <= time_d;
      grid_q      <= grid_d;
      launch_q    <= launch_d;
      restart_q   <= restart_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      bursts_q    <= bursts_d;
      setup_q     <= setup_d;
      sum_q       <= sum_d;
      taken_q     <= taken_d;
      needed_q    <= needed_d;
      mean_q      <= mean_d;
      med_q       <= med_d;
      coil_q      <= coil_d;
      drv_q       <= drv_d;
      lsn_q       <= lsn_d;
      mch_q       <= mch_d;
      men_q       <= men_d;
      kind_mean_q <= kind_mean_d;
      res_adc_q   <= res_adc_d;
      res_done_q  <= res_done_d;
      if (cmd_i.load_out) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pcs_pkg::REG_SETTLE_A: settle_a_q  <= cfg_wdata_i;
          pcs_pkg::REG_SETTLE_B: settle_b_q  <= cfg_wdata_i;
          pcs_pkg::REG_BURST:    burst_q     <= cfg_wdata_i[7:0];
          pcs_pkg::REG_PERIOD:   period_us_q <= cfg_wdata_i[7:0];
          pcs_pkg::REG_MEAN:     mean_cnt_q  <= cfg_wdata_i[7:0];
          pcs_pkg::REG_ATTEN:    atten_q     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    late_q    <= late_d;
    res_val_q <= res_val_d;
    if (cmd_i.load_item) begin
      op_q     <= in_op_i;
      tx_mux_q <= in_data_i[1:0];
      tx_ch_q  <= in_data_i[4:2];
      rx_mux_q <= in_data_i[6:5];
      rx_ch_q  <= in_data_i[9:7];
      freq_q   <= in_data_i[13:10];
      smp_q    <= in_data_i[25:14];
    end
    if (cmd_i.load_out) begin
      out_q <= {6'd0, res_val_q, res_done_q, phase_q != pcs_pkg::PH_IDLE, res_adc_q,
                atten_q, men_q, mch_q, lsn_q, drv_q, coil_q};
    end
  end

  assign sts_o.need_div = need_div;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o    = out_vld_q;
  assign out_data_o     = out_q;

endmodule

>>> rtl/core/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Item sequencer: accept, execute, optional divide, output load.
// ----------------------------------------------------------------------------
module pcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output pcs_pkg::cmd_t cmd_o,
  input  pcs_pkg::sts_t sts_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.need_div ? S_DSTART : S_OUT;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the transaction
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

>>> rtl/core/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_props
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_props (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pcs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // one item in flight: no new acceptance right after one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[12] && m_axis_tdata[9:6] == 4'hF)
    else $error("done while busy or mux enabled");

  a_drive_not_listen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[2] && m_axis_tdata[12])
    else $error("driving while listening or idle");

endmodule

bind pen_coil_scan_sequencer pcs_props u_pcs_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
